// ===== hdl/tdffra_pkg.sv =====
// package for the top-down first-fit range allocator
// holds widths, reset constants, status codes, cell commands and the fsm state type
// no dependencies
`default_nettype none

package tdffra_pkg;

    localparam int DATA_W          = 32;
    localparam int STATUS_W        = 3;
    localparam int MAX_REGIONS_DEF = 16;
    localparam int PAGE_SIZE_DEF   = 4096;

    localparam logic [DATA_W-1:0] TOP_RESET = 32'h8000_0000;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_BAD_LENGTH = 3'd1,
        ST_HINT_HIGH  = 3'd2,
        ST_NO_SPACE   = 3'd3,
        ST_FULL       = 3'd4,
        ST_NOT_FOUND  = 3'd5
    } t_status;

    typedef enum logic {
        ACT_MAP   = 1'b0,
        ACT_UNMAP = 1'b1
    } t_action;

    // one table entry, inclusive bounds
    typedef struct packed {
        logic [DATA_W-1:0] start_addr;
        logic [DATA_W-1:0] last_addr;
    } t_region;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_FROM_LEFT,
        CELL_FROM_RIGHT
    } t_cell_cmd;

    typedef struct packed {
        t_cell_cmd cmd;
        t_region   new_region;
    } t_cell_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_TAIL,
        S_UPDATE,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== hdl/tdffra_if.sv =====
// valid/ready channel interfaces for the range allocator requests and results
// depends on tdffra_pkg
`default_nettype none

interface tdffra_in_if;
    import tdffra_pkg::*;
    logic                     valid;
    logic                     ready;
    logic                     action;
    logic        [DATA_W-1:0] address;
    logic signed [DATA_W-1:0] length;
    logic        [DATA_W-1:0] heap_end;

    modport source (output valid, output action, output address, output length,
                    output heap_end, input ready);
    modport sink   (input valid, input action, input address, input length,
                    input heap_end, output ready);
endinterface

interface tdffra_out_if;
    import tdffra_pkg::*;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] start_address;
    t_status           status;

    modport source (output valid, output start_address, output status, input ready);
    modport sink   (input valid, input start_address, input status, output ready);
endinterface

`default_nettype wire

// ===== hdl/top_down_first_fit_range_allocator.sv =====
// top level of the top-down first-fit range allocator
// depends on tdffra_pkg, tdffra_in_if, tdffra_out_if and tdffra_cell
// holds the controller, the page rounding and the fit arithmetic
`default_nettype none

// The block keeps up to MAX_REGIONS address ranges in a row of cells, highest
// range in cell 0. A map beat rounds its length up to whole pages (PAGE_SIZE
// must be a power of two) and places the range first-fit from the top: just
// below top_of_user, then in each gap between neighbors, then down to heap_end.
// An unmap beat removes the range whose start equals the address. Each request
// beat produces exactly one result beat with start_address and status. One
// request is handled at a time: a beat that fails its early checks goes
// straight to the done state, every other beat passes through the walk,
// tail, update and done states in that order. The walk rotates the cell row
// through cell 0: every entry passes the head once, one per cycle, and after
// a full turn the row is back in order, then the update state inserts or
// removes an entry by a parallel shift. The result sits in an output register,
// so a result that waits to be taken does not stop the next request from being
// accepted. The user must write top_of_user through the config port only while
// the block is idle; the block does not enforce this. There is no read-back.
module top_down_first_fit_range_allocator #(
    parameter int MAX_REGIONS = tdffra_pkg::MAX_REGIONS_DEF,
    parameter int PAGE_SIZE   = tdffra_pkg::PAGE_SIZE_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [tdffra_pkg::DATA_W-1:0] i_cfg_wr_data,
    tdffra_in_if.sink                          i_in,
    tdffra_out_if.source                       o_out
);
    import tdffra_pkg::*;

    // count must hold MAX_REGIONS itself; positions only need an index
    localparam int CW = $clog2(MAX_REGIONS + 1);
    localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam logic [DATA_W:0] PAGE_MASK = (DATA_W + 1)'(PAGE_SIZE - 1);

    // ---------------------------------------------------------------
    // registers
    // ---------------------------------------------------------------
    t_state            r_state,      n_state;
    logic [CW-1:0]     r_step,       n_step;       // rotation step = entry at the head
    logic [CW-1:0]     r_count,      n_count;      // live entries
    logic              r_found,      n_found;      // fit or match seen
    logic [IW-1:0]     r_pos,        n_pos;        // insert or remove position
    logic              r_is_unmap,   n_is_unmap;
    logic [DATA_W-1:0] r_addr,       n_addr;
    logic [DATA_W-1:0] r_len,        n_len;        // page-rounded length
    logic [DATA_W-1:0] r_heap,       n_heap;
    logic [DATA_W-1:0] r_upper,      n_upper;      // start of the last live entry seen
    t_region           r_new,        n_new;        // range to insert
    t_status           r_status,     n_status;
    logic              r_out_valid,  n_out_valid;
    logic [DATA_W-1:0] r_out_start,  n_out_start;
    t_status           r_out_status, n_out_status;
    logic [DATA_W-1:0] r_top;                      // top_of_user

    // ---------------------------------------------------------------
    // cell row
    // ---------------------------------------------------------------
    t_region   w_region [MAX_REGIONS];
    t_cell_ctl w_ctl    [MAX_REGIONS];
    t_region   w_head;

    assign w_head = w_region[0];

    for (genvar k = 0; k < MAX_REGIONS; k++) begin : g_cell
        // per-cell command: rotate during the walk, shift around r_pos on update
        always_comb begin
            w_ctl[k].new_region = r_new;
            w_ctl[k].cmd        = CELL_HOLD;
            if (r_state == S_WALK) begin
                w_ctl[k].cmd = CELL_FROM_RIGHT;
            end else if (r_state == S_UPDATE && r_found) begin
                if (r_is_unmap) begin
                    if (r_pos <= IW'(k)) begin
                        w_ctl[k].cmd = CELL_FROM_RIGHT;
                    end
                end else if (r_pos == IW'(k)) begin
                    w_ctl[k].cmd = CELL_LOAD;
                end else if (r_pos < IW'(k)) begin
                    w_ctl[k].cmd = CELL_FROM_LEFT;
                end
            end
        end

        tdffra_cell u_cell (
            .i_clk    (i_clk),
            .i_ctl    (w_ctl[k]),
            .i_left   (w_region[(k == 0) ? 0 : k - 1]),
            .i_right  (w_region[(k + 1) % MAX_REGIONS]),
            .o_region (w_region[k])
        );
    end

    // ---------------------------------------------------------------
    // request checks at acceptance
    // ---------------------------------------------------------------
    logic              w_in_beat;
    logic [DATA_W-1:0] w_len_raw;
    logic [DATA_W:0]   w_len_rnd;
    logic              w_bad_len;

    assign w_in_beat = i_in.valid && i_in.ready;
    assign w_len_raw = $unsigned(i_in.length);
    assign w_len_rnd = ({1'b0, w_len_raw} + PAGE_MASK) & ~PAGE_MASK;
    // sign bit set, zero, or a rounded length past 31 bits
    assign w_bad_len = (w_len_raw == '0) || w_len_raw[DATA_W-1] ||
                       (w_len_rnd[DATA_W:DATA_W-1] != 2'b00);

    // ---------------------------------------------------------------
    // fit arithmetic, one add and compare per cycle
    // ---------------------------------------------------------------
    logic [DATA_W-1:0] w_walk_upper;   // upper bound of the gap above the head entry
    logic [DATA_W:0]   w_walk_need;
    logic              w_walk_fit;
    logic [DATA_W-1:0] w_tail_upper;
    logic [DATA_W:0]   w_tail_need;
    logic              w_tail_fit;
    logic              w_step_live;

    assign w_step_live  = (r_step < r_count);
    assign w_walk_upper = (r_step == '0) ? r_top : r_upper;
    // space = upper - last - 1, fits when len + last < upper
    assign w_walk_need  = {1'b0, r_len} + {1'b0, w_head.last_addr};
    assign w_walk_fit   = w_walk_need < {1'b0, w_walk_upper};
    assign w_tail_upper = (r_count == '0) ? r_top : r_upper;
    // space = upper - heap_end, fits when len + heap_end <= upper
    assign w_tail_need  = {1'b0, r_len} + {1'b0, r_heap};
    assign w_tail_fit   = w_tail_need <= {1'b0, w_tail_upper};

    assign i_in.ready = (r_state == S_IDLE);

    // ---------------------------------------------------------------
    // next state and outputs
    // ---------------------------------------------------------------
    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        n_count      = r_count;
        n_found      = r_found;
        n_pos        = r_pos;
        n_is_unmap   = r_is_unmap;
        n_addr       = r_addr;
        n_len        = r_len;
        n_heap       = r_heap;
        n_upper      = r_upper;
        n_new        = r_new;
        n_status     = r_status;
        n_out_valid  = r_out_valid;
        n_out_start  = r_out_start;
        n_out_status = r_out_status;

        // result beat taken
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_beat) begin
                    n_is_unmap = (t_action'(i_in.action) == ACT_UNMAP);
                    n_addr     = i_in.address;
                    n_len      = w_len_rnd[DATA_W-1:0];
                    n_heap     = i_in.heap_end;
                    n_found    = 1'b0;
                    n_step     = '0;
                    n_status   = ST_OK;
                    n_state    = S_WALK;
                    if (t_action'(i_in.action) == ACT_MAP) begin
                        // hint, then length, then table-full
                        if (i_in.address >= r_top) begin
                            n_status = ST_HINT_HIGH;
                            n_state  = S_DONE;
                        end else if (w_bad_len) begin
                            n_status = ST_BAD_LENGTH;
                            n_state  = S_DONE;
                        end else if (r_count >= CW'(MAX_REGIONS)) begin
                            n_status = ST_FULL;
                            n_state  = S_DONE;
                        end
                    end
                end
            end

            S_WALK: begin
                if (w_step_live) begin
                    n_upper = w_head.start_addr;
                    if (!r_found) begin
                        if (r_is_unmap) begin
                            if (w_head.start_addr == r_addr) begin
                                n_found = 1'b1;
                                n_pos   = r_step[IW-1:0];
                            end
                        end else if (w_walk_fit) begin
                            n_found                = 1'b1;
                            n_pos                  = r_step[IW-1:0];
                            n_new.start_addr       = w_walk_upper - r_len;
                            n_new.last_addr        = w_walk_upper - DATA_W'(1);
                        end
                    end
                end
                n_step = r_step + CW'(1);
                // row is back in order after a full turn
                if (r_step == CW'(MAX_REGIONS - 1)) begin
                    n_state = S_TAIL;
                end
            end

            S_TAIL: begin
                if (!r_is_unmap && !r_found && w_tail_fit) begin
                    n_found          = 1'b1;
                    n_pos            = r_count[IW-1:0];
                    n_new.start_addr = w_tail_upper - r_len;
                    n_new.last_addr  = w_tail_upper - DATA_W'(1);
                end
                n_state = S_UPDATE;
            end

            S_UPDATE: begin
                if (r_found) begin
                    n_status = ST_OK;
                    n_count  = r_is_unmap ? r_count - CW'(1) : r_count + CW'(1);
                end else begin
                    n_status = r_is_unmap ? ST_NOT_FOUND : ST_NO_SPACE;
                end
                n_state = S_DONE;
            end

            S_DONE: begin
                // wait until the output register is free
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_start  = (r_status == ST_OK && !r_is_unmap) ?
                                   r_new.start_addr : '0;
                    n_state      = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_found     <= 1'b0;
            r_step      <= '0;
            r_top       <= TOP_RESET;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_found     <= n_found;
            r_step      <= n_step;
            if (i_cfg_wr_en) begin
                r_top <= i_cfg_wr_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_is_unmap   <= n_is_unmap;
        r_addr       <= n_addr;
        r_len        <= n_len;
        r_heap       <= n_heap;
        r_upper      <= n_upper;
        r_new        <= n_new;
        r_status     <= n_status;
        r_out_start  <= n_out_start;
        r_out_status <= n_out_status;
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.start_address = r_out_start;
    assign o_out.status        = r_out_status;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_REGIONS))
        else $error("region count above table size");

    a_count_only_on_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_UPDATE) |=> $stable(r_count))
        else $error("region count changed outside table update");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result beat raised outside the done state");

    a_fail_zero_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != ST_OK) |-> (r_out_start == '0))
        else $error("failed request carries a nonzero start");

endmodule

`default_nettype wire

// ===== hdl/tdffra_cell.sv =====
// one entry of the region table; takes a new entry or a neighbor's entry
// depends on tdffra_pkg
`default_nettype none

module tdffra_cell (
    input  wire logic                 i_clk,
    input  wire tdffra_pkg::t_cell_ctl i_ctl,
    input  wire tdffra_pkg::t_region  i_left,
    input  wire tdffra_pkg::t_region  i_right,
    output tdffra_pkg::t_region       o_region
);
    import tdffra_pkg::*;

    t_region r_region;
    t_region n_region;

    always_comb begin
        unique case (i_ctl.cmd)
            CELL_LOAD:       n_region = i_ctl.new_region;
            CELL_FROM_LEFT:  n_region = i_left;
            CELL_FROM_RIGHT: n_region = i_right;
            default:         n_region = r_region;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_region <= n_region;
    end

    assign o_region = r_region;

endmodule

`default_nettype wire
